>>> rtl/core/dual_key_debounce_press_classifier_unit_defines.svh
// Assertion macros shared by the classifier RTL.
`ifndef DUAL_KEY_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define DUAL_KEY_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DKPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dkpc assertion failed");

// Next-cycle implication, disabled during reset.
`define DKPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dkpc assertion failed");

`endif

>>> rtl/core/dkpc_pkg.sv
package dkpc_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCAN_PERIOD_MS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_MS  = 2'd2;

   localparam logic [7:0]  DEBOUNCE_COUNT_RESET = 8'd3;
   localparam logic [9:0]  SCAN_PERIOD_MS_RESET = 10'd10;
   localparam logic [15:0] LONG_PRESS_MS_RESET  = 16'd1000;

   typedef enum logic [1:0] {
      PHASE_IDLE            = 2'd0,
      PHASE_PRESS_CONFIRM   = 2'd1,
      PHASE_PRESSED         = 2'd2,
      PHASE_RELEASE_CONFIRM = 2'd3
   } key_phase_type;

   typedef enum logic [2:0] {
      EVENT_NONE         = 3'd0,
      EVENT_KEY_ONE_SHORT = 3'd1,
      EVENT_KEY_TWO_LONG = 3'd2,
      EVENT_KEY_TWO_RELEASED = 3'd3,
      EVENT_KEY_TWO_HELD = 3'd4
   } key_event_type;

   typedef struct packed {
      key_phase_type phase;
      logic [7:0]    confirm_count;
      logic [15:0]   press_time;
      logic          long_reported;
      logic          previous_level;
   } key_state_type;

   typedef struct packed {
      logic [7:0]  debounce_count;
      logic [9:0]  scan_period_ms;
      logic [15:0] long_press_ms;
   } key_config_type;

   typedef struct packed {
      key_state_type state;
      key_event_type key_event;
   } key_result_type;

   localparam key_state_type KEY_STATE_RESET = '{
      phase:          PHASE_IDLE,
      confirm_count:  8'd0,
      press_time:     16'd0,
      long_reported:  1'b0,
      previous_level: 1'b1
   };

   // One scan tick of one key's debounce machine.
   function automatic key_result_type key_step(input key_state_type cur,
                                               input logic level,
                                               input logic is_key_two,
                                               input key_config_type cfg);
      key_result_type res;
      logic [7:0]     bumped;
      logic [16:0]    sum;
      logic [15:0]    new_time;
      logic           confirmed;
      res.state     = cur;
      res.key_event = EVENT_NONE;
      bumped    = (cur.confirm_count == 8'hFF) ? 8'hFF : cur.confirm_count + 8'd1;
      confirmed = (bumped >= cfg.debounce_count);
      sum       = {1'b0, cur.press_time} + {7'd0, cfg.scan_period_ms};
      new_time  = sum[16] ? 16'hFFFF : sum[15:0];
      case (cur.phase)
         PHASE_IDLE: begin
            if (!level && cur.previous_level) begin
               res.state.phase         = PHASE_PRESS_CONFIRM;
               res.state.confirm_count = 8'd0;
            end
         end
         PHASE_PRESS_CONFIRM: begin
            if (!level) begin
               res.state.confirm_count = bumped;
               if (confirmed) begin
                  res.state.phase         = PHASE_PRESSED;
                  res.state.press_time    = 16'd0;
                  res.state.long_reported = 1'b0;
               end
            end else begin
               res.state.phase = PHASE_IDLE;
            end
         end
         PHASE_PRESSED: begin
            if (!level) begin
               res.state.press_time = new_time;
               if (!cur.long_reported && (new_time >= cfg.long_press_ms)) begin
                  res.state.long_reported = 1'b1;
                  if (is_key_two) begin
                     res.key_event = EVENT_KEY_TWO_LONG;
                  end
               end
            end else begin
               res.state.phase         = PHASE_RELEASE_CONFIRM;
               res.state.confirm_count = 8'd0;
            end
         end
         PHASE_RELEASE_CONFIRM: begin
            if (level) begin
               res.state.confirm_count = bumped;
               if (confirmed) begin
                  res.state.phase = PHASE_IDLE;
                  if (is_key_two) begin
                     res.key_event = EVENT_KEY_TWO_RELEASED;
                  end else if (cur.press_time < cfg.long_press_ms) begin
                     res.key_event = EVENT_KEY_ONE_SHORT;
                  end
               end
            end else begin
               res.state.phase = PHASE_PRESSED;
            end
         end
         default: begin
            res.state.phase = PHASE_IDLE;
         end
      endcase
      res.state.previous_level = level;
      return res;
   endfunction

endpackage

>>> rtl/core/dual_key_debounce_press_classifier_unit.sv
// Path: a beat accepted on req passes the input register and then the result
// register, which drives rsp_valid; a stall on rsp can hold it in either one.
// Throughput: one scan tick per cycle unless rsp_stall holds the result; the
// input and result registers let a new beat enter while a finished result waits.
// Reset (synchronous, active high) puts both keys in idle with released levels
// and loads the register defaults: debounce 3, scan period 10 ms, long 1000 ms.
`include "dual_key_debounce_press_classifier_unit_defines.svh"

module dual_key_debounce_press_classifier_unit
   import dkpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Scan tick input channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_key_one_level,
   input  logic                       req_key_two_level,
   // Event result channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_key_event,
   // Register write port.
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Configuration registers. The user must change them only while the block is
   // idle, which the block does not enforce; the key logic reads them directly.
   key_config_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count <= DEBOUNCE_COUNT_RESET;
         cfg_ff.scan_period_ms <= SCAN_PERIOD_MS_RESET;
         cfg_ff.long_press_ms  <= LONG_PRESS_MS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_COUNT: cfg_ff.debounce_count <= csr_write_data[7:0];
            CSR_SCAN_PERIOD_MS: cfg_ff.scan_period_ms <= csr_write_data[9:0];
            CSR_LONG_PRESS_MS:  cfg_ff.long_press_ms  <= csr_write_data[15:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // Input register. The tick sitting here is processed and written into the
   // result register in the cycle that register is free or being drained.
   logic in_valid_ff;
   logic in_key_one_ff;
   logic in_key_two_ff;
   logic rsp_valid_ff;
   logic [2:0] rsp_key_event_ff;
   logic advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_key_one_ff <= req_key_one_level;
         in_key_two_ff <= req_key_two_level;
      end
   end

   // Per-key machine state; index 0 is key one, index 1 is key two.
   key_state_type  key_ff [2];
   key_state_type  key_in [2];
   key_result_type key_one_res;
   key_result_type key_two_res;
   key_event_type  tick_event;
   logic           commit;

   assign commit = in_valid_ff && advance;

   // Both keys step in parallel; the priority rule then picks what commits.
   always_comb begin
      key_one_res = key_step(key_ff[0], in_key_one_ff, 1'b0, cfg_ff);
      key_two_res = key_step(key_ff[1], in_key_two_ff, 1'b1, cfg_ff);
   end

   // Next state: when key one reports an event, key two is not processed at
   // all on this tick, so its state (including its previous level) holds.
   always_comb begin
      key_in[0] = key_ff[0];
      key_in[1] = key_ff[1];
      if (commit) begin
         key_in[0] = key_one_res.state;
         if (key_one_res.key_event == EVENT_NONE) begin
            key_in[1] = key_two_res.state;
         end
      end
   end

   // Tick result: key one first, then key two, then the held report.
   always_comb begin
      if (key_one_res.key_event != EVENT_NONE) begin
         tick_event = key_one_res.key_event;
      end else if (key_two_res.key_event != EVENT_NONE) begin
         tick_event = key_two_res.key_event;
      end else if (key_two_res.state.phase == PHASE_PRESSED) begin
         tick_event = EVENT_KEY_TWO_HELD;
      end else begin
         tick_event = EVENT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= KEY_STATE_RESET;
         key_ff[1] <= KEY_STATE_RESET;
      end else begin
         key_ff[0] <= key_in[0];
         key_ff[1] <= key_in[1];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_key_event_ff <= tick_event;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = rsp_key_event_ff;

   // A committed tick always lands in the result register.
   `DKPC_ASSERT_NEXT(a_commit_fills_rsp, clock, reset, commit, rsp_valid_ff)
   // Key two keeps its state on a tick where key one reported an event.
   `DKPC_ASSERT_NEXT(a_key_two_skipped, clock, reset,
      commit && (key_one_res.key_event != EVENT_NONE), $stable(key_ff[1]))
   // Key machines only move when a tick commits.
   `DKPC_ASSERT_NEXT(a_state_holds_idle, clock, reset,
      !commit, $stable(key_ff[0]) && $stable(key_ff[1]))

endmodule
